@@ src/abpa_pkg.sv @@
`default_nettype none

package abpa_pkg;

    localparam int CH_W       = 4;
    localparam int RAW_W      = 32;
    localparam int FS_W       = 16;
    localparam int AVG_W      = 7;
    localparam int KEPT_W     = 11;
    localparam int Q_W        = 7;
    localparam int PCT_W      = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int PERCENT_FULL  = 100;
    localparam int MAX_BURST_DEF = 1024;

    localparam logic [CH_W-1:0] CH_SEL_RESET = 4'd0;
    localparam logic [FS_W-1:0] FS_RESET     = 16'd3350;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE     = 1'd1;

    typedef struct packed {
        logic capture;
        logic start_pct;
        logic start_avg;
        logic add_full;
        logic add_quot;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic keep;
        logic clamp;
        logic last;
        logic count_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ src/abpa_div.sv @@
`default_nettype none

module abpa_div #(
    parameter int DIV_W = 24,
    parameter int DVS_W = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIV_W-1:0]        dividend,
    input  wire logic [DVS_W-1:0]        divisor,
    output logic                         done,
    output logic [abpa_pkg::Q_W-1:0]     quotient
);

    localparam int STEP_W = $clog2(abpa_pkg::Q_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [DIV_W-1:0]          dvs_reg, dvs_next;
    logic [abpa_pkg::Q_W-1:0]  q_reg, q_next;
    logic                      ge;

    assign ge = rem_reg >= dvs_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend;
            dvs_next  = DIV_W'(divisor) << (abpa_pkg::Q_W - 1);
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dvs_reg) : rem_reg;
            q_next   = {q_reg[abpa_pkg::Q_W-2:0], ge};
            dvs_next = dvs_reg >> 1;
            if (step_reg == STEP_W'(abpa_pkg::Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

@@ src/abpa_dp.sv @@
`default_nettype none

module abpa_dp #(
    parameter int MAX_BURST = abpa_pkg::MAX_BURST_DEF,
    parameter int CNT_W     = 11,
    parameter int SUM_W     = 17,
    parameter int DVS_W     = 16,
    parameter int DIV_W     = 24
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [abpa_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [abpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [abpa_pkg::CH_W-1:0]         channel,
    input  wire logic [abpa_pkg::RAW_W-1:0]        raw_sample,
    input  wire logic                              last_sample,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [abpa_pkg::AVG_W-1:0]             average_percent,
    output logic [abpa_pkg::KEPT_W-1:0]            kept_count,
    input  wire abpa_pkg::ctl_cmd_t                cmd,
    output abpa_pkg::dp_stat_t                     stat
);

    logic [abpa_pkg::CH_W-1:0]    sel_reg, sel_next;
    logic [abpa_pkg::FS_W-1:0]    fs_reg, fs_next;
    logic [abpa_pkg::CH_W-1:0]    ch_reg;
    logic [abpa_pkg::RAW_W-1:0]   raw_reg;
    logic                         last_reg;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [abpa_pkg::AVG_W-1:0]   avg_reg;
    logic [abpa_pkg::KEPT_W-1:0]  kept_reg;

    logic [abpa_pkg::RAW_W-1:0]   mag;
    logic [abpa_pkg::PCT_W-1:0]   pct_dvd;
    logic                         div_start;
    logic [DIV_W-1:0]             div_dvd;
    logic [DVS_W-1:0]             div_dvs;
    logic                         div_done;
    logic [abpa_pkg::Q_W-1:0]     div_q;

    assign mag     = raw_reg[abpa_pkg::RAW_W-1] ? (abpa_pkg::RAW_W'(0) - raw_reg) : raw_reg;
    assign pct_dvd = abpa_pkg::PCT_W'(mag[abpa_pkg::FS_W-1:0])
                     * abpa_pkg::PCT_W'(abpa_pkg::PERCENT_FULL);

    assign div_start = cmd.start_pct | cmd.start_avg;
    assign div_dvd   = cmd.start_avg ? DIV_W'(sum_reg) : DIV_W'(pct_dvd);
    assign div_dvs   = cmd.start_avg ? DVS_W'(cnt_reg) : DVS_W'(fs_reg);

    abpa_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        stat.keep       = (ch_reg == sel_reg) && (raw_reg != '0)
                          && (cnt_reg < CNT_W'(MAX_BURST));
        stat.clamp      = mag >= abpa_pkg::RAW_W'(fs_reg);
        stat.last       = last_reg;
        stat.count_zero = cnt_reg == '0;
        stat.div_done   = div_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        sel_next = sel_reg;
        fs_next  = fs_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                abpa_pkg::REG_CHANNEL_SELECT: sel_next = cfg_wdata[abpa_pkg::CH_W-1:0];
                abpa_pkg::REG_FULL_SCALE:     fs_next  = cfg_wdata[abpa_pkg::FS_W-1:0];
                default:                      sel_next = sel_reg;
            endcase
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.load_out)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
        else if (cmd.add_full)
        begin
            sum_next = sum_reg + SUM_W'(abpa_pkg::PERCENT_FULL);
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.add_quot)
        begin
            sum_next = sum_reg + SUM_W'(div_q);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= abpa_pkg::CH_SEL_RESET;
            fs_reg        <= abpa_pkg::FS_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            fs_reg        <= fs_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel;
            raw_reg  <= raw_sample;
            last_reg <= last_sample;
        end
        if (cmd.load_out)
        begin
            avg_reg  <= (cnt_reg == '0) ? '0 : abpa_pkg::AVG_W'(div_q);
            kept_reg <= abpa_pkg::KEPT_W'(cnt_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign average_percent = avg_reg;
    assign kept_count      = kept_reg;

endmodule

`default_nettype wire

@@ src/abpa_ctrl.sv @@
`default_nettype none

module abpa_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire abpa_pkg::dp_stat_t    stat,
    output abpa_pkg::ctl_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_DIVP = 6'b000100,
        S_FIN  = 6'b001000,
        S_DIVA = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.keep && !stat.clamp)
                begin
                    cmd.start_pct = 1'b1;
                    state_next    = S_DIVP;
                end
                else
                begin
                    cmd.add_full = stat.keep;
                    state_next   = stat.last ? S_FIN : S_IDLE;
                end
            end
            S_DIVP:
            begin
                if (stat.div_done)
                begin
                    cmd.add_quot = 1'b1;
                    state_next   = stat.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (stat.count_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.start_avg = 1'b1;
                    state_next    = S_DIVA;
                end
            end
            S_DIVA:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ src/adc_burst_percent_averager.sv @@
// Per request: a skipped or clamped sample is only evaluated; a kept, unclamped one also
// needs the percent division in the shared one-bit-per-cycle restoring divider.
// A last request then runs the average division unless the burst is empty; the result
// waits for a free output register and sits there while the next requests are taken.
// Reset (asynchronous, active low) clears sum, count and output valid, and sets
// channel_select to 0 and full_scale to 3350.
`default_nettype none

module adc_burst_percent_averager #(
    parameter int MAX_BURST = abpa_pkg::MAX_BURST_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [abpa_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [abpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [abpa_pkg::CH_W-1:0]         channel,
    input  wire logic [abpa_pkg::RAW_W-1:0]        raw_sample,
    input  wire logic                              last_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [abpa_pkg::AVG_W-1:0]             average_percent,
    output logic [abpa_pkg::KEPT_W-1:0]            kept_count
);

    localparam int CNT_W  = $clog2(MAX_BURST + 1);
    localparam int SUM_W  = $clog2(abpa_pkg::PERCENT_FULL * MAX_BURST + 1);
    localparam int DVS_W  = (abpa_pkg::FS_W > CNT_W) ? abpa_pkg::FS_W : CNT_W;
    localparam int DIV_A  = (abpa_pkg::PCT_W > SUM_W) ? abpa_pkg::PCT_W : SUM_W;
    localparam int DIV_W  = (DIV_A > DVS_W + abpa_pkg::Q_W) ? DIV_A : DVS_W + abpa_pkg::Q_W;

    abpa_pkg::ctl_cmd_t cmd;
    abpa_pkg::dp_stat_t stat;

    abpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abpa_dp #(
        .MAX_BURST (MAX_BURST),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .DVS_W     (DVS_W),
        .DIV_W     (DIV_W)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .channel         (channel),
        .raw_sample      (raw_sample),
        .last_sample     (last_sample),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .average_percent (average_percent),
        .kept_count      (kept_count),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

`default_nettype wire
